// File: design/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared codes and types for the front/middle/back queue unit: operation
// codes, result status codes and the control state type.
// ----------------------------------------------------------------------------
package fmbq_pkg;

	// Field widths fixed by the transaction format
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_MIDDLE  = 3'd4;
	localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Control states, one-hot
	typedef enum logic [1:0] {
		CTL_IDLE = 2'b01,
		CTL_EXEC = 2'b10
	} ctl_state_t;

endpackage

// File: design/front_middle_back_queue_unit.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_unit
// Bounded queue with push/pop at the front, middle or back. Contents live in
// two ring-buffer halves (front half, back half) held in synchronous RAMs;
// the back half keeps as many entries as the front half or one more.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Payload (low bit up)
//  --------  ---  ----------------------  ----------------------------------------
//  s_axis    in   s_axis_tvalid/tready    operation[3], push_value[VALUE_BITS]
//  m_axis    out  m_axis_tvalid/tready    status[2], pop_value[VALUE_BITS],
//                                         occupancy[clog2(CAPACITY+1)]
//
//  Each operation runs in steps: the accept edge reads the boundary entry of
//  each half (one read port per RAM); the commit edge writes at most one entry
//  per half, updates heads and counts and loads the output register.
//  A result not yet taken holds the second step; no new transaction is taken
//  until the pending one has committed. Reset clears heads, counts and control;
//  the RAMs need no clearing since an unwritten entry is never used.
//
module front_middle_back_queue_unit #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_axis_tdata: operation[2:0], push_value, zero pad
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [((fmbq_pkg::OP_W + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// m_axis_tdata: status[1:0], pop_value, occupancy, zero pad
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [((fmbq_pkg::STATUS_W + VALUE_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
		m_axis_tdata
);
	import fmbq_pkg::*;

	localparam int HALF   = (CAPACITY + 1) / 2;
	localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int CW     = $clog2(HALF + 1);
	localparam int SW     = CW + 1;
	localparam int OW     = $clog2(CAPACITY + 1);
	localparam int OUT_TW = ((STATUS_W + VALUE_BITS + OW + 7) / 8) * 8;

	localparam logic [HW-1:0] LAST_SLOT = HW'(HALF - 1);
	localparam logic [SW-1:0] HALF_S    = SW'(HALF);
	localparam logic [OW-1:0] CAP_O     = OW'(CAPACITY);

	// ring index arithmetic, one compare-subtract wrap
	function automatic logic [HW-1:0] slot_at(input logic [HW-1:0] h, input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(off);
		if (s >= HALF_S) begin
			s = s - HALF_S;
		end
		return s[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] slot_inc(input logic [HW-1:0] h);
		return (h == LAST_SLOT) ? '0 : h + HW'(1);
	endfunction

	function automatic logic [HW-1:0] slot_dec(input logic [HW-1:0] h);
		return (h == '0) ? LAST_SLOT : h - HW'(1);
	endfunction

	// control and queue state
	ctl_state_t             state_q;
	logic [HW-1:0]          fh_q, bh_q;
	logic [CW-1:0]          fc_q, bc_q;

	// stage 1 captures
	logic [OP_W-1:0]        op_s1;
	logic [VALUE_BITS-1:0]  val_s1;
	logic [VALUE_BITS-1:0]  rd_f_s1, rd_b_s1;

	// output register
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [VALUE_BITS-1:0]  pop_q;
	logic [OW-1:0]          occ_q;

	// RAMs
	logic [VALUE_BITS-1:0]  mem_f [HALF];
	logic [VALUE_BITS-1:0]  mem_b [HALF];

	logic                   in_fire, commit;
	logic [OP_W-1:0]        in_op;
	logic [HW-1:0]          raddr_f, raddr_b;

	logic                   we_f, we_b;
	logic [HW-1:0]          waddr_f, waddr_b;
	logic [VALUE_BITS-1:0]  wdata_f, wdata_b;
	logic [HW-1:0]          nfh, nbh;
	logic [CW-1:0]          nfc, nbc;
	logic [STATUS_W-1:0]    res_status;
	logic [VALUE_BITS-1:0]  res_value;
	logic [OW-1:0]          total;
	logic                   f_lt_b, full, empty;

	assign s_axis_tready = (state_q == CTL_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_op         = s_axis_tdata[OP_W-1:0];
	assign commit        = (state_q == CTL_EXEC) && (!out_valid_q || m_axis_tready);

	// read addresses: boundary entries chosen by the incoming operation
	always_comb begin
		if (in_op == OP_POP_FRONT || fc_q == '0) begin
			raddr_f = fh_q;
		end else begin
			raddr_f = slot_at(fh_q, fc_q - CW'(1));
		end
		if (in_op == OP_POP_BACK && bc_q != '0) begin
			raddr_b = slot_at(bh_q, bc_q - CW'(1));
		end else begin
			raddr_b = bh_q;
		end
	end

	// front half RAM
	always_ff @(posedge clk) begin
		if (we_f) begin
			mem_f[waddr_f] <= wdata_f;
		end
		if (in_fire) begin
			rd_f_s1 <= mem_f[raddr_f];
		end
	end

	// back half RAM
	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr_b] <= wdata_b;
		end
		if (in_fire) begin
			rd_b_s1 <= mem_b[raddr_b];
		end
	end

	// operation capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= in_op;
			val_s1 <= s_axis_tdata[OP_W +: VALUE_BITS];
		end
	end

	// execute: writes, head/count update, result
	always_comb begin
		total      = OW'(fc_q) + OW'(bc_q);
		f_lt_b     = fc_q < bc_q;
		full       = total >= CAP_O;
		empty      = total == '0;
		we_f       = 1'b0;
		we_b       = 1'b0;
		waddr_f    = fh_q;
		waddr_b    = bh_q;
		wdata_f    = val_s1;
		wdata_b    = val_s1;
		nfh        = fh_q;
		nbh        = bh_q;
		nfc        = fc_q;
		nbc        = bc_q;
		res_status = ST_DONE;
		res_value  = '0;
		case (op_s1)
			OP_PUSH_FRONT: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (empty) begin
					we_b    = 1'b1;
					waddr_b = slot_dec(bh_q);
					nbh     = slot_dec(bh_q);
					nbc     = bc_q + CW'(1);
				end else if (f_lt_b) begin
					we_f    = 1'b1;
					waddr_f = slot_dec(fh_q);
					nfh     = slot_dec(fh_q);
					nfc     = fc_q + CW'(1);
				end else begin
					// last of front half crosses to the back half
					we_b    = 1'b1;
					waddr_b = slot_dec(bh_q);
					wdata_b = rd_f_s1;
					nbh     = slot_dec(bh_q);
					nbc     = bc_q + CW'(1);
					we_f    = 1'b1;
					waddr_f = slot_dec(fh_q);
					nfh     = slot_dec(fh_q);
				end
			end
			OP_PUSH_MIDDLE: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (f_lt_b) begin
					we_f    = 1'b1;
					waddr_f = slot_at(fh_q, fc_q);
					nfc     = fc_q + CW'(1);
				end else begin
					we_b    = 1'b1;
					waddr_b = slot_dec(bh_q);
					nbh     = slot_dec(bh_q);
					nbc     = bc_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (f_lt_b) begin
					// first of back half crosses to the front half
					we_f    = 1'b1;
					waddr_f = slot_at(fh_q, fc_q);
					wdata_f = rd_b_s1;
					nfc     = fc_q + CW'(1);
					nbh     = slot_inc(bh_q);
					we_b    = 1'b1;
					waddr_b = slot_at(bh_q, bc_q);
				end else begin
					we_b    = 1'b1;
					waddr_b = slot_at(bh_q, bc_q);
					nbc     = bc_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					res_status = ST_EMPTY;
					res_value  = '1;
				end else if (fc_q == '0) begin
					res_value = rd_b_s1;
					nbh       = slot_inc(bh_q);
					nbc       = bc_q - CW'(1);
				end else begin
					res_value = rd_f_s1;
					nfh       = slot_inc(fh_q);
					if (f_lt_b) begin
						we_f    = 1'b1;
						waddr_f = slot_at(fh_q, fc_q);
						wdata_f = rd_b_s1;
						nbh     = slot_inc(bh_q);
						nbc     = bc_q - CW'(1);
					end else begin
						nfc = fc_q - CW'(1);
					end
				end
			end
			OP_POP_MIDDLE: begin
				if (empty) begin
					res_status = ST_EMPTY;
					res_value  = '1;
				end else if (f_lt_b) begin
					res_value = rd_b_s1;
					nbh       = slot_inc(bh_q);
					nbc       = bc_q - CW'(1);
				end else begin
					res_value = rd_f_s1;
					nfc       = fc_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					res_status = ST_EMPTY;
					res_value  = '1;
				end else if (fc_q == bc_q) begin
					// last of front half refills the back half's head
					res_value = rd_b_s1;
					we_b      = 1'b1;
					waddr_b   = slot_dec(bh_q);
					wdata_b   = rd_f_s1;
					nbh       = slot_dec(bh_q);
					nfc       = fc_q - CW'(1);
				end else begin
					res_value = rd_b_s1;
					nbc       = bc_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (!commit) begin
			we_f = 1'b0;
			we_b = 1'b0;
		end
	end

	// control, heads and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
			fh_q    <= '0;
			bh_q    <= '0;
			fc_q    <= '0;
			bc_q    <= '0;
		end else begin
			case (state_q)
				CTL_IDLE: begin
					if (in_fire) begin
						state_q <= CTL_EXEC;
					end
				end
				CTL_EXEC: begin
					if (commit) begin
						state_q <= CTL_IDLE;
						fh_q    <= nfh;
						bh_q    <= nbh;
						fc_q    <= nfc;
						bc_q    <= nbc;
					end
				end
				default: begin
					state_q <= CTL_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= res_status;
			pop_q    <= res_value;
			occ_q    <= OW'(nfc) + OW'(nbc);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TW'({occ_q, pop_q, status_q});

endmodule
